// ===== src/sct_pkg.sv =====
// shared types, codes, constants and helpers for the sine/cosine/tangent unit
`default_nettype none
package sct_pkg;

  localparam int WF = 59;
  localparam logic [63:0] PI_Q62 = 64'hC90F_DAA2_2168_C235;
  localparam logic signed [63:0] QMAX = 64'sh7FFF_FFFF_FFFF_FFFF;

  localparam logic [1:0] KIND_SIN = 2'd0;
  localparam logic [1:0] KIND_COS = 2'd1;
  localparam logic [1:0] KIND_TAN = 2'd2;

  localparam logic [4:0] OP_NONE     = 5'd0;
  localparam logic [4:0] OP_LOAD     = 5'd1;
  localparam logic [4:0] OP_RED      = 5'd2;
  localparam logic [4:0] OP_FOLD     = 5'd3;
  localparam logic [4:0] OP_HALVE    = 5'd4;
  localparam logic [4:0] OP_MUL      = 5'd5;
  localparam logic [4:0] OP_WR_XX    = 5'd6;
  localparam logic [4:0] OP_HS       = 5'd7;
  localparam logic [4:0] OP_WR_S     = 5'd8;
  localparam logic [4:0] OP_HC       = 5'd9;
  localparam logic [4:0] OP_WR_T1    = 5'd10;
  localparam logic [4:0] OP_WR_T2    = 5'd11;
  localparam logic [4:0] OP_DBL      = 5'd12;
  localparam logic [4:0] OP_SIGN     = 5'd13;
  localparam logic [4:0] OP_DIV_INIT = 5'd14;
  localparam logic [4:0] OP_DIV_STEP = 5'd15;
  localparam logic [4:0] OP_OUT      = 5'd16;

  localparam logic [2:0] SEL_XX  = 3'd0;
  localparam logic [2:0] SEL_SXX = 3'd1;
  localparam logic [2:0] SEL_SX  = 3'd2;
  localparam logic [2:0] SEL_CXX = 3'd3;
  localparam logic [2:0] SEL_SC  = 3'd4;
  localparam logic [2:0] SEL_CC  = 3'd5;
  localparam logic [2:0] SEL_SS  = 3'd6;

  typedef struct packed {
    logic [4:0] op;
    logic [2:0] sel;
  } cmd_t;

  typedef struct packed {
    logic       red_last;
    logic       x_small;
    logic       n_end;
    logic       k_zero;
    logic       mul_done;
    logic       div_last;
    logic       c_zero;
    logic [1:0] kind;
  } stat_t;

  // round(2^59 / n!), magnitudes; sign is negative when n mod 4 >= 2
  localparam logic [63:0] COEF_MAG [20] = '{
    64'd576460752303423488, 64'd576460752303423488, 64'd288230376151711744,
    64'd96076792050570581,  64'd24019198012642645,  64'd4803839602528529,
    64'd800639933754755,    64'd114377133393536,    64'd14297141674192,
    64'd1588571297132,      64'd158857129713,       64'd14441557247,
    64'd1203463104,         64'd92574085,           64'd6612435,
    64'd440829,             64'd27552,              64'd1621,
    64'd90,                 64'd5
  };

  function automatic logic signed [63:0] qadd(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [64:0] sum;
    sum = 65'(a) + 65'(b);
    if (sum > 65'(QMAX)) qadd = QMAX;
    else if (sum < -65'(QMAX)) qadd = -QMAX;
    else qadd = sum[63:0];
  endfunction

endpackage
`default_nettype wire

// ===== src/sct_mul.sv =====
// sequential 64x64 fixed-point multiplier, four 32x32 partial products
`default_nettype none
module sct_mul import sct_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [63:0] a,
  input  wire logic signed [63:0] b,
  output logic                    done,
  output logic signed [63:0]      p
);

  logic [63:0]  ua, ub;
  logic         ng;
  logic [127:0] acc;
  logic [63:0]  pp;
  logic [1:0]   pofs;
  logic [2:0]   cnt;
  logic         run;
  logic [31:0]  ha, hb;
  logic [63:0]  prod;
  logic         sat;
  logic signed [63:0] r;

  assign ha   = cnt[1] ? ua[63:32] : ua[31:0];
  assign hb   = cnt[0] ? ub[63:32] : ub[31:0];
  assign prod = 64'(ha) * 64'(hb);

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= 3'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= 3'd0;
      end else if (run) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd4) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // accumulator starts at half an lsb of the result for rounding
  always_ff @(posedge clk) begin
    if (start) begin
      ua  <= a[63] ? 64'(-a) : 64'(a);
      ub  <= b[63] ? 64'(-b) : 64'(b);
      ng  <= a[63] != b[63];
      acc <= 128'd1 << (WF - 1);
    end else if (run) begin
      if (cnt != 3'd4) begin
        pp   <= prod;
        pofs <= {1'b0, cnt[1]} + {1'b0, cnt[0]};
      end
      if (cnt != 3'd0) acc <= acc + (128'(pp) << {pofs, 5'd0});
    end
  end

  assign sat = |acc[127:122];
  assign r   = sat ? QMAX : $signed({1'b0, acc[121:59]});
  assign p   = ng ? -r : r;

endmodule
`default_nettype wire

// ===== src/sct_ctrl.sv =====
// controller state machine sequencing reduction, series, doubling and division
`default_nettype none
module sct_ctrl import sct_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  input  wire stat_t stat,
  output cmd_t       cmd,
  output logic       busy
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_RED   = 5'd1;
  localparam logic [4:0] S_FOLD  = 5'd2;
  localparam logic [4:0] S_HALV  = 5'd3;
  localparam logic [4:0] S_M_XX  = 5'd4;
  localparam logic [4:0] S_W_XX  = 5'd5;
  localparam logic [4:0] S_M_HS  = 5'd6;
  localparam logic [4:0] S_W_HS  = 5'd7;
  localparam logic [4:0] S_M_SX  = 5'd8;
  localparam logic [4:0] S_W_SX  = 5'd9;
  localparam logic [4:0] S_M_HC  = 5'd10;
  localparam logic [4:0] S_W_HC  = 5'd11;
  localparam logic [4:0] S_DCHK  = 5'd12;
  localparam logic [4:0] S_M_SC  = 5'd13;
  localparam logic [4:0] S_W_SC  = 5'd14;
  localparam logic [4:0] S_M_CC  = 5'd15;
  localparam logic [4:0] S_W_CC  = 5'd16;
  localparam logic [4:0] S_M_SS  = 5'd17;
  localparam logic [4:0] S_W_SS  = 5'd18;
  localparam logic [4:0] S_SIGN  = 5'd19;
  localparam logic [4:0] S_DINIT = 5'd20;
  localparam logic [4:0] S_DIV   = 5'd21;
  localparam logic [4:0] S_OUT   = 5'd22;

  logic [4:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign busy = state != S_IDLE;

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    cmd.sel    = SEL_XX;
    unique case (state)
      S_IDLE: if (start) begin
        cmd.op     = OP_LOAD;
        state_next = S_RED;
      end
      S_RED: begin
        cmd.op = OP_RED;
        if (stat.red_last) state_next = S_FOLD;
      end
      S_FOLD: begin
        cmd.op     = OP_FOLD;
        state_next = S_HALV;
      end
      S_HALV: begin
        cmd.op = OP_HALVE;
        if (stat.x_small) state_next = S_M_XX;
      end
      S_M_XX: begin
        cmd.op     = OP_MUL;
        cmd.sel    = SEL_XX;
        state_next = S_W_XX;
      end
      S_W_XX: if (stat.mul_done) begin
        cmd.op     = OP_WR_XX;
        state_next = S_M_HS;
      end
      S_M_HS: begin
        cmd.op     = OP_MUL;
        cmd.sel    = SEL_SXX;
        state_next = S_W_HS;
      end
      S_W_HS: if (stat.mul_done) begin
        cmd.op     = OP_HS;
        state_next = stat.n_end ? S_M_SX : S_M_HS;
      end
      S_M_SX: begin
        cmd.op     = OP_MUL;
        cmd.sel    = SEL_SX;
        state_next = S_W_SX;
      end
      S_W_SX: if (stat.mul_done) begin
        cmd.op     = OP_WR_S;
        state_next = S_M_HC;
      end
      S_M_HC: begin
        cmd.op     = OP_MUL;
        cmd.sel    = SEL_CXX;
        state_next = S_W_HC;
      end
      S_W_HC: if (stat.mul_done) begin
        cmd.op     = OP_HC;
        state_next = stat.n_end ? S_DCHK : S_M_HC;
      end
      S_DCHK: state_next = stat.k_zero ? S_SIGN : S_M_SC;
      S_M_SC: begin
        cmd.op     = OP_MUL;
        cmd.sel    = SEL_SC;
        state_next = S_W_SC;
      end
      S_W_SC: if (stat.mul_done) begin
        cmd.op     = OP_WR_T1;
        state_next = S_M_CC;
      end
      S_M_CC: begin
        cmd.op     = OP_MUL;
        cmd.sel    = SEL_CC;
        state_next = S_W_CC;
      end
      S_W_CC: if (stat.mul_done) begin
        cmd.op     = OP_WR_T2;
        state_next = S_M_SS;
      end
      S_M_SS: begin
        cmd.op     = OP_MUL;
        cmd.sel    = SEL_SS;
        state_next = S_W_SS;
      end
      S_W_SS: if (stat.mul_done) begin
        cmd.op     = OP_DBL;
        state_next = S_DCHK;
      end
      S_SIGN: begin
        cmd.op     = OP_SIGN;
        state_next = (stat.kind == KIND_TAN && !stat.c_zero) ? S_DINIT : S_OUT;
      end
      S_DINIT: begin
        cmd.op     = OP_DIV_INIT;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.op = OP_DIV_STEP;
        if (stat.div_last) state_next = S_OUT;
      end
      S_OUT: begin
        cmd.op     = OP_OUT;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== src/sct_dp.sv =====
// datapath: turn reduction, halving, series registers, doubling and divider
`default_nettype none
module sct_dp import sct_pkg::*; #(
  parameter int FACT_ENTRIES    = 20,
  parameter int ANGLE_FRAC_BITS = 24
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cmd_t               cmd,
  output stat_t                   stat,
  input  wire logic [1:0]         in_kind,
  input  wire logic signed [31:0] in_angle,
  input  wire logic [24:0]        threshold,
  output logic                    done,
  output logic [47:0]             value,
  output logic                    saturated
);

  localparam int GF  = ANGLE_FRAC_BITS + 31;
  localparam int XSH = WF - GF;
  localparam int TSH = WF - ANGLE_FRAC_BITS;
  localparam logic [63:0] TWOPI = 64'((65'(PI_Q62) + (65'd1 << (60 - GF))) >> (61 - GF));
  localparam logic [63:0] PIG   = 64'((65'(PI_Q62) + (65'd1 << (61 - GF))) >> (62 - GF));
  localparam logic [3:0]  RED_CNT0 = 4'(60 - GF);
  localparam logic [4:0]  LS = 5'(((FACT_ENTRIES - 1) % 2 == 1) ? FACT_ENTRIES - 1
                                                                 : FACT_ENTRIES - 2);
  localparam logic [4:0]  LC = 5'(((FACT_ENTRIES - 1) % 2 == 0) ? FACT_ENTRIES - 1
                                                                 : FACT_ENTRIES - 2);

  logic [1:0]  kind_r;
  logic        neg;
  logic [63:0] r, d, x;
  logic [3:0]  rcnt;
  logic [5:0]  k;
  logic [4:0]  n;
  logic signed [63:0] xx, s, c, t1, t2;
  logic [63:0] nb, rem, cm;
  logic [49:0] q;
  logic        over;
  logic [6:0]  dcnt;

  logic        a_neg;
  logic [32:0] amag;
  logic        thr_inf;
  logic [63:0] thr_ext;
  logic signed [63:0] ma, mb, mul_p, cf;
  logic        mul_done;
  logic [63:0] rem_s;
  logic        ge;
  logic [49:0] q_new;

  sct_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.op == OP_MUL),
    .a     (ma),
    .b     (mb),
    .done  (mul_done),
    .p     (mul_p)
  );

  always_comb begin
    ma = s;
    mb = s;
    unique case (cmd.sel)
      SEL_XX:  begin ma = $signed(x); mb = $signed(x); end
      SEL_SXX: begin ma = s; mb = xx; end
      SEL_SX:  begin ma = s; mb = $signed(x); end
      SEL_CXX: begin ma = c; mb = xx; end
      SEL_SC:  begin ma = s; mb = c; end
      SEL_CC:  begin ma = c; mb = c; end
      SEL_SS:  begin ma = s; mb = s; end
      default: begin ma = s; mb = s; end
    endcase
  end

  assign cf = n[1] ? -$signed(COEF_MAG[n]) : $signed(COEF_MAG[n]);

  assign a_neg   = in_angle[31];
  assign amag    = a_neg ? (33'h1_0000_0000 - {1'b0, in_angle}) : {1'b0, in_angle};
  assign thr_inf = (threshold >> (ANGLE_FRAC_BITS + 2)) != 25'd0;
  assign thr_ext = 64'(threshold) << TSH;

  assign rem_s = {rem[62:0], nb[63]};
  assign ge    = rem_s >= cm;
  assign q_new = {q[48:0], ge};

  assign stat.red_last = rcnt == 4'd0;
  assign stat.x_small  = thr_inf || (x <= thr_ext);
  assign stat.n_end    = n <= 5'd1;
  assign stat.k_zero   = k == 6'd0;
  assign stat.mul_done = mul_done;
  assign stat.div_last = dcnt == 7'd0;
  assign stat.c_zero   = c == 64'sd0;
  assign stat.kind     = kind_r;

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        kind_r <= in_kind;
        neg    <= a_neg;
        r      <= 64'(amag) << 31;
        d      <= TWOPI << RED_CNT0;
        rcnt   <= RED_CNT0;
      end
      OP_RED: begin
        if (r >= d) r <= r - d;
        d    <= d >> 1;
        rcnt <= rcnt - 4'd1;
      end
      OP_FOLD: begin
        if (r > PIG) begin
          x   <= (TWOPI - r) << XSH;
          neg <= ~neg;
        end else begin
          x <= r << XSH;
        end
        k <= 6'd0;
        n <= LS;
        s <= 64'sd0;
      end
      OP_HALVE: if (!stat.x_small) begin
        x <= x >> 1;
        k <= k + 6'd1;
      end
      OP_WR_XX: xx <= mul_p;
      OP_HS: begin
        s <= qadd(mul_p, cf);
        n <= n - 5'd2;
      end
      OP_WR_S: begin
        s <= mul_p;
        c <= 64'sd0;
        n <= LC;
      end
      OP_HC: begin
        c <= qadd(mul_p, cf);
        n <= n - 5'd2;
      end
      OP_WR_T1: t1 <= mul_p;
      OP_WR_T2: t2 <= mul_p;
      OP_DBL: begin
        s <= qadd(t1, t1);
        c <= qadd(t2, -mul_p);
        k <= k - 6'd1;
      end
      OP_SIGN: if (neg) s <= -s;
      OP_DIV_INIT: begin
        nb   <= s[63] ? 64'(-s) : 64'(s);
        cm   <= c[63] ? 64'(-c) : 64'(c);
        rem  <= 64'd0;
        q    <= 50'd0;
        over <= 1'b0;
        dcnt <= 7'd95;
      end
      OP_DIV_STEP: begin
        nb   <= nb << 1;
        rem  <= ge ? rem_s - cm : rem_s;
        q    <= q_new;
        over <= over || (q_new > (50'd1 << 48));
        dcnt <= dcnt - 7'd1;
      end
      default: ;
    endcase
  end

  // result formatting
  logic signed [63:0] v;
  logic [63:0] vm;
  logic [37:0] q32;
  logic        rnd, qn, tsat;
  logic [49:0] q_r, lim, q_f;
  logic [47:0] out_value;
  logic        out_sat;

  always_comb begin
    v   = (kind_r == KIND_SIN) ? s : c;
    vm  = v[63] ? 64'(-v) : 64'(v);
    q32 = 38'((65'(vm) + (65'd1 << (WF - 33))) >> (WF - 32));
    rnd = {rem, 1'b0} >= {1'b0, cm};
    q_r = over ? q : q + 50'(rnd);
    // an overflowed quotient is never zero, whatever bits are left in q
    qn  = (s[63] != c[63]) && (over || (q_r != 50'd0));
    lim = qn ? (50'd1 << 47) : ((50'd1 << 47) - 50'd1);
    tsat = over || (q_r > lim);
    q_f = tsat ? lim : q_r;
    out_value = 48'd0;
    out_sat   = 1'b0;
    unique case (kind_r)
      KIND_SIN, KIND_COS: out_value = v[63] ? -48'(q32) : 48'(q32);
      KIND_TAN: begin
        if (c == 64'sd0) begin
          out_sat   = 1'b1;
          out_value = s[63] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
        end else begin
          out_sat   = tsat;
          out_value = qn ? -q_f[47:0] : q_f[47:0];
        end
      end
      default: begin
        out_value = 48'd0;
        out_sat   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= cmd.op == OP_OUT;
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT) begin
      value     <= out_value;
      saturated <= out_sat;
    end
  end

endmodule
`default_nettype wire

// ===== src/sin_cos_tan_series_halving.sv =====
// top level: register port, controller and datapath of the sin/cos/tan unit
//
//  channel   signals                              handshake
//  request   kind, angle                          start & !busy
//  result    value, saturated                     done, one cycle, no stall
//  register  psel penable pwrite paddr pwdata     write in access phase
//
// one request at a time; busy is high from acceptance until the result strobe.
// a request goes through the reduction steps, the halving steps and the
// multiplies on the shared multiplier (FACT_ENTRIES+2 multiplies for the
// series, 3 per halving undone), plus the divider steps for tangent.
// rst is synchronous and returns the threshold to 167772.
`default_nettype none
module sin_cos_tan_series_halving import sct_pkg::*; #(
  parameter int FACT_ENTRIES    = 20,
  parameter int ANGLE_FRAC_BITS = 24
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         kind,
  input  wire logic signed [31:0] angle,
  output logic                    done,
  output logic signed [47:0]      value,
  output logic                    saturated,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic [24:0] threshold;
  cmd_t        cmd;
  stat_t       stat;
  logic [47:0] value_u;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) threshold <= 25'd167772;
    else if (psel && penable && pwrite && pready && !paddr[2]) threshold <= pwdata[24:0];
  end

  assign prdata = paddr[2] ? 32'd0 : {7'd0, threshold};

  sct_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  sct_dp #(
    .FACT_ENTRIES    (FACT_ENTRIES),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_kind   (kind),
    .in_angle  (angle),
    .threshold (threshold),
    .done      (done),
    .value     (value_u),
    .saturated (saturated)
  );

  assign value = $signed(value_u);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("request accepted but unit not busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result strobe while still busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe longer than one cycle");

  a_mul_busy: assert property (@(posedge clk) disable iff (rst)
    stat.mul_done |-> busy) else $error("multiplier finished while idle");

endmodule
`default_nettype wire

// ===== dv/sin_cos_tan_series_halving_tb.sv =====
// self-checking testbench for the sine/cosine/tangent series-and-halving unit
`timescale 1ns / 100ps
`default_nettype none
module sin_cos_tan_series_halving_tb;
  import sct_pkg::*;

  localparam logic [2:0] ADDR_THRESHOLD = 3'd0;
  localparam logic [2:0] ADDR_UNUSED    = 3'd4;
  localparam longint CYCLE_LIMIT = 64'd4000000;

  typedef struct packed {
    logic signed [47:0] value;
    logic               saturated;
  } trig_result_t;

  logic clk, rst, start, busy, done, saturated, psel, penable, pwrite, pready;
  logic [1:0] kind;
  logic signed [31:0] angle;
  logic signed [47:0] value;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  sin_cos_tan_series_halving u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind), .angle(angle),
    .done(done), .value(value), .saturated(saturated), .psel(psel),
    .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  trig_result_t expected_q[$];
  logic [24:0] threshold;
  int errors;
  longint cycles;
  bit quiet;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // rounding product in Q4.59, saturating
  function automatic logic signed [63:0] fx_mul(logic signed [63:0] a,
                                                logic signed [63:0] b);
    logic neg;
    logic [63:0] ua, ub;
    logic [127:0] p;
    logic [127:0] r;
    neg = (a < 0) != (b < 0);
    ua = a < 0 ? -a : a;
    ub = b < 0 ? -b : b;
    p = 128'(ua) * 128'(ub) + (128'd1 << (WF - 1));
    r = p >> WF;
    if (r > 128'(QMAX)) r = 128'(QMAX);
    fx_mul = neg ? -$signed(r[63:0]) : $signed(r[63:0]);
  endfunction

  function automatic logic signed [63:0] fx_add(logic signed [63:0] a,
                                                logic signed [63:0] b);
    logic signed [64:0] t;
    t = 65'(a) + 65'(b);
    if (t > 65'(QMAX)) fx_add = QMAX;
    else if (t < -65'(QMAX)) fx_add = -QMAX;
    else fx_add = t[63:0];
  endfunction

  function automatic logic signed [63:0] series_coef(int n);
    logic [63:0] f, c;
    f = 64'd1;
    for (int i = 2; i <= n; i++) f = f * i;
    c = ((64'd1 << WF) + f / 2) / f;
    series_coef = (n % 4 < 2) ? $signed(c) : -$signed(c);
  endfunction

  function automatic logic [47:0] round_q32(logic signed [63:0] v);
    logic [63:0] m;
    m = v < 0 ? -v : v;
    m = (m + (64'd1 << (WF - 33))) >> (WF - 32);
    round_q32 = v < 0 ? -m[47:0] : m[47:0];
  endfunction

  function automatic trig_result_t predict_trig(logic [1:0] k_in, logic signed [31:0] a_in);
    trig_result_t res;
    logic neg, over, qn;
    logic [63:0] amag, twopi, pig, r, x, thr, sm, cm, q, rem, lim;
    logic signed [63:0] xs, xx, s, c, sc, cc, ss;
    int halvings;
    neg = a_in[31];
    amag = neg ? 64'h1_0000_0000 - {32'd0, a_in} : {32'd0, a_in};
    twopi = (PI_Q62 + (64'd1 << 5)) >> 6;
    pig = (PI_Q62 + (64'd1 << 6)) >> 7;
    r = (amag << 31) % twopi;
    if (r > pig) begin
      r = twopi - r;
      neg = !neg;
    end
    x = r << 4;
    thr = (64'(threshold) >> 26) != 0 ? '1 : 64'(threshold) << 35;
    halvings = 0;
    while (x > thr) begin
      x = x >> 1;
      halvings++;
    end
    xs = $signed(x);
    xx = fx_mul(xs, xs);
    s = 0;
    for (int n = 19; n >= 1; n -= 2) s = fx_add(fx_mul(s, xx), series_coef(n));
    s = fx_mul(s, xs);
    c = 0;
    for (int n = 18; n >= 0; n -= 2) c = fx_add(fx_mul(c, xx), series_coef(n));
    for (int i = 0; i < halvings; i++) begin
      sc = fx_mul(s, c);
      cc = fx_mul(c, c);
      ss = fx_mul(s, s);
      s = fx_add(sc, sc);
      c = fx_add(cc, -ss);
    end
    if (neg) s = -s;
    res = '0;
    if (k_in == KIND_SIN) res.value = round_q32(s);
    else if (k_in == KIND_COS) res.value = round_q32(c);
    else if (k_in == KIND_TAN) begin
      sm = s < 0 ? -s : s;
      cm = c < 0 ? -c : c;
      qn = (s < 0) != (c < 0);
      if (cm == 0) begin
        res.saturated = 1'b1;
        res.value = s < 0 ? -(48'sd1 <<< 47) : {1'b0, {47{1'b1}}};
      end else begin
        q = 0;
        rem = 0;
        over = 1'b0;
        for (int i = 95; i >= 0; i--) begin
          if (!over) begin
            rem = (rem << 1) | (i >= 32 ? 64'((sm >> (i - 32)) & 1) : 64'd0);
            q = q << 1;
            if (rem >= cm) begin
              rem = rem - cm;
              q[0] = 1'b1;
            end
            if (q > (64'd1 << 48)) over = 1'b1;
          end
        end
        if (!over && rem * 2 >= cm) q++;
        if (q == 0) qn = 1'b0;
        lim = qn ? (64'd1 << 47) : (64'd1 << 47) - 1;
        if (over || q > lim) begin
          q = lim;
          res.saturated = 1'b1;
        end
        res.value = qn ? -q[47:0] : q[47:0];
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    trig_result_t want;
    cycles <= cycles + 1;
    if (!rst && done) begin
      if (expected_q.size() == 0) report_mismatch("unexpected result", value, 0);
      else begin
        want = expected_q.pop_front();
        if (value !== want.value) report_mismatch("value", value, want.value);
        if (saturated !== want.saturated) report_mismatch("saturated", saturated, want.saturated);
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // start stays high after acceptance until an idle cycle or a drain drops it
  task automatic send_request(logic [1:0] k_in, logic signed [31:0] a_in);
    while (!quiet && $urandom_range(0, 99) < 9) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    kind <= k_in;
    angle <= a_in;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_q.push_back(predict_trig(k_in, a_in));
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_THRESHOLD) threshold = data[24:0];
  endtask

  task automatic test_directed();
    logic [1:0] kinds[4] = '{KIND_SIN, KIND_COS, KIND_TAN, 2'd3};
    foreach (kinds[i]) begin
      send_request(kinds[i], 32'sh7FFF_FFFF);
      send_request(kinds[i], 32'sh8000_0000);
      send_request(kinds[i], 32'sd0);
    end
    send_request(KIND_TAN, 32'sd26353589);  // near pi/2
    send_request(KIND_TAN, -32'sd26353589);
    send_request(KIND_SIN, 32'sd52707179);  // near pi, reduction tie region
    send_request(KIND_COS, -32'sd52707179);
    send_request(KIND_SIN, 32'sd105414357);
    send_request(KIND_TAN, 32'sd1);
    send_request(KIND_TAN, -32'sd1);
    drain();
  endtask

  task automatic test_thresholds();
    logic [31:0] thr_list[5] = '{32'd1, 32'h0100_0000, 32'd0, 32'd60000000, 32'd167772};
    foreach (thr_list[i]) begin
      write_reg(ADDR_THRESHOLD, thr_list[i]);
      for (int j = 0; j < 6; j++) send_request(2'($urandom_range(0, 2)), $signed($urandom()));
      send_request(KIND_TAN, 32'sd26353589);
      drain();
    end
    write_reg(ADDR_UNUSED, 32'd5);  // ignored index
    send_request(KIND_SIN, 32'sd20000000);
    drain();
  endtask

  task automatic test_random();
    for (int i = 0; i < 1050; i++) begin
      quiet = (i >= 300 && i < 450);
      if (i % 250 == 249) begin
        drain();
        write_reg(ADDR_THRESHOLD, $urandom_range(1, 16777216));
      end
      send_request($urandom_range(0, 99) < 3 ? 2'd3 : 2'($urandom_range(0, 2)),
                   $urandom_range(0, 3) == 0 ? $signed($urandom())
                                             : $signed(32'($urandom_range(0, 120000000))) *
                                               ($urandom_range(0, 1) ? 1 : -1));
    end
    quiet = 1'b0;
    drain();
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    kind = '0;
    angle = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    threshold = 25'd167772;
    errors = 0;
    cycles = 0;
    quiet = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_thresholds();
    test_random();
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
`default_nettype wire

// ===== sin_cos_tan_series_halving.f =====
src/sct_pkg.sv
src/sct_mul.sv
src/sct_ctrl.sv
src/sct_dp.sv
src/sin_cos_tan_series_halving.sv
dv/sin_cos_tan_series_halving_tb.sv
